// ===== hw/rtl/spq_pkg.sv =====
// Package for the sorted priority queue.
// Holds the depth, the counter width, the operation and status codes and
// the transfer structs. It depends on nothing.
package spq_pkg;

	localparam int DEPTH   = 64;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int COUNT_W = 7;

	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_DEQUEUE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		op_t                operation;
		logic signed [31:0] data;
		logic signed [15:0] priority_req;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic signed [31:0]   removed_data;
		logic signed [15:0]   removed_priority;
		logic [COUNT_W-1:0]   count;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic signed [15:0] prio;
	} entry_t;

	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t new_entry;
	} cell_ctrl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One slot of the sorted chain: holds one entry and moves it to a neighbor.
// Depends on spq_pkg for the entry and control structs.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic               occupied,
	input  logic               prev_keep,
	input  spq_pkg::entry_t    prev_entry,
	input  spq_pkg::entry_t    next_entry,
	output logic               keep,
	output spq_pkg::entry_t    entry
);
	import spq_pkg::*;

	entry_t entry_q;

	// An occupied slot whose priority is at least the new one stays put.
	assign keep  = occupied && (entry_q.prio >= ctrl.new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (!keep) begin
				if (prev_keep) begin
					entry_q <= ctrl.new_entry;
				end else begin
					entry_q <= prev_entry;
				end
			end
		end else if (ctrl.deq) begin
			entry_q <= next_entry;
		end
	end

endmodule

// ===== hw/rtl/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue.
// Depends on spq_pkg and spq_cell.
//
// The request channel (req_valid, req_stall, req) carries one operation per
// transfer: an enqueue of a data word with a signed priority, or a dequeue of
// the head entry. The response channel (rsp_valid, rsp_stall, rsp) returns
// exactly one result per request with the status, the removed entry and the
// entry count after the operation.
//
// Entries live in a chain of DEPTH cells sorted with the highest priority at
// cell zero. Every cell compares its priority with the incoming one in
// parallel, so an insert or a removal completes in the cycle of the transfer.
// A request is taken every cycle while req_stall is low; its result is
// registered in the output register, or in the skid register if that is busy.
//
// Reset clears the entry count and empties the response buffer; cell contents
// are not reset. The response side has an output register and a skid
// register, so one request is still taken while a response waits. Once both
// are full, req_stall rises and stays high until the receiver takes a
// response.
module sorted_priority_queue_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spq_pkg::rsp_t rsp
);
	import spq_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic             out_v_q;
	logic             skid_v_q;
	rsp_t             out_q;
	rsp_t             skid_q;

	logic       accept;
	logic       take_out;
	logic       full;
	logic       empty;
	cell_ctrl_t ctrl;
	rsp_t       res;

	logic   keep  [DEPTH];
	entry_t entry [DEPTH];

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign req_stall = skid_v_q;
	assign accept   = req_valid && !skid_v_q;
	assign take_out = out_v_q && !rsp_stall;

	assign ctrl.enq       = accept && (req.operation == OP_ENQUEUE) && !full;
	assign ctrl.deq       = accept && (req.operation == OP_DEQUEUE) && !empty;
	assign ctrl.new_entry = '{data: req.data, prio: req.priority_req};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   prev_keep;
		entry_t prev_entry;
		entry_t next_entry;

		if (i == 0) begin : g_head
			assign prev_keep  = 1'b1;
			assign prev_entry = '0;
		end else begin : g_body
			assign prev_keep  = keep[i-1];
			assign prev_entry = entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_entry = '0;
		end else begin : g_inner
			assign next_entry = entry[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (cnt_q > CNT_W'(i)),
			.prev_keep  (prev_keep),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.keep       (keep[i]),
			.entry      (entry[i])
		);
	end

	always_comb begin
		res = '0;
		res.status = ST_DONE;
		res.count  = COUNT_W'(cnt_q);
		if (req.operation == OP_ENQUEUE) begin
			if (full) begin
				res.status = ST_OVERFLOW;
			end else begin
				res.count = COUNT_W'(cnt_q + 1'b1);
			end
		end else begin
			if (empty) begin
				res.status = ST_UNDERFLOW;
			end else begin
				res.removed_data     = entry[0].data;
				res.removed_priority = entry[0].prio;
				res.count            = COUNT_W'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (ctrl.enq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (ctrl.deq) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (skid_v_q) begin
				if (take_out) begin
					skid_v_q <= 1'b0;
				end
			end else if (accept) begin
				if (!out_v_q || take_out) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (take_out) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take_out) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (!out_v_q || take_out) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds depth");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q > CNT_W'(1)) |-> (entry[0].prio >= entry[1].prio))
		else $error("head entries out of priority order");

	a_underflow_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.operation == OP_DEQUEUE && empty) |=>
		(rsp_valid && cnt_q == '0))
		else $error("underflow changed the queue");

endmodule
